// ===== hdl/wrp_pkg.sv =====
// Shared types, status codes and tag constants for the WAV RIFF header parser.
package wrp_pkg;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_BAD_TAG   = 4'd1,
        ST_TRUNC     = 4'd2,
        ST_FMT_SHORT = 4'd3,
        ST_NOT_PCM   = 4'd4,
        ST_NOT_16BIT = 4'd5,
        ST_ZERO_CH   = 4'd6,
        ST_NO_FMT    = 4'd7,
        ST_NO_DATA   = 4'd8,
        ST_ODD_DATA  = 4'd9
    } status_t;

    typedef struct packed {
        logic [31:0] body_len;
        logic [31:0] body_start;
        logic [15:0] sample_bits;
        logic [31:0] rate_hz;
        logic [15:0] channels;
        status_t     status;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] PCM_BITS = 16'd16;
    localparam logic [31:0] FMT_MIN  = 32'd16;
    localparam logic [31:0] POS_MAX  = 32'hFFFF_FFFF;

    function automatic logic [7:0] riff_byte(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h52;
            2'd1: r = 8'h49;
            2'd2: r = 8'h46;
            2'd3: r = 8'h46;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] wave_byte(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h57;
            2'd1: r = 8'h41;
            2'd2: r = 8'h56;
            2'd3: r = 8'h45;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/wav_riff_header_parser_top.sv =====
// Top level of the WAV RIFF header parser: input stream, parse core, result register.
// The result is registered and appears on the master side in the cycle after the final byte transfer.
// Throughput: one byte per cycle; the parse state updates in the cycle of each transfer.
// A final byte is held off only while the previous result still waits in the result register.
// Reset (rst_n low, asynchronous) returns the parser to the RIFF header and drops any result.
module wav_riff_header_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tlast,  // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wrp_pkg::TDATA_W-1:0]   m_tdata   // status, channels, rate_hz,
                                                    // sample_bits, body_start,
                                                    // body_len; zero fill on top
);

    logic             take;
    wrp_pkg::result_t result;
    wrp_pkg::result_t out_reg;
    logic             out_valid_reg;

    // non-final bytes never produce a result, so only a final byte waits on the output
    assign s_tready = !out_valid_reg || m_tready || !s_tlast;
    assign take     = s_tvalid && s_tready;

    wrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (take && s_tlast)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = wrp_pkg::TDATA_W'(out_reg);

endmodule

// ===== hdl/wrp_core.sv =====
// Byte-wise RIFF/WAVE parse state and the status and fields for the final byte.
module wrp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output wrp_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_CHDR = 3'd1,
        PH_BODY = 3'd2,
        PH_PAD  = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    phase_t           phase_reg, phase_next;
    kind_t            kind_reg, kind_next;
    wrp_pkg::status_t err_reg, err_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remain_reg, remain_next;
    logic [15:0] fcode_reg, fcode_next;
    logic [15:0] stg_ch_reg, stg_ch_next;
    logic [31:0] stg_rate_reg, stg_rate_next;
    logic [15:0] stg_bits_reg, stg_bits_next;
    logic [31:0] stg_off_reg, stg_off_next;
    logic [15:0] cap_ch_reg, cap_ch_next;
    logic [31:0] cap_rate_reg, cap_rate_next;
    logic [15:0] cap_bits_reg, cap_bits_next;
    logic [31:0] cap_off_reg, cap_off_next;
    logic [31:0] cap_bytes_reg, cap_bytes_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;

    logic        fin;
    logic        mismatch;
    logic [31:0] body_off;
    wrp_pkg::status_t status;

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        idx_next       = idx_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        remain_next    = remain_reg;
        fcode_next     = fcode_reg;
        stg_ch_next    = stg_ch_reg;
        stg_rate_next  = stg_rate_reg;
        stg_bits_next  = stg_bits_reg;
        stg_off_next   = stg_off_reg;
        cap_ch_next    = cap_ch_reg;
        cap_rate_next  = cap_rate_reg;
        cap_bits_next  = cap_bits_reg;
        cap_off_next   = cap_off_reg;
        cap_bytes_next = cap_bytes_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        fin            = 1'b0;
        mismatch       = 1'b0;
        body_off       = size_reg - remain_reg;

        if (err_reg == wrp_pkg::ST_OK && pos_reg == wrp_pkg::POS_MAX)
        begin
            err_next   = wrp_pkg::ST_TRUNC;
            phase_next = PH_DONE;
        end
        else if (err_reg == wrp_pkg::ST_OK)
        begin
            unique case (phase_reg)
                PH_RIFF:
                begin
                    mismatch = (idx_reg < 4'd4 && data_byte != wrp_pkg::riff_byte(idx_reg[1:0]))
                            || (idx_reg >= 4'd8 && idx_reg < 4'd12
                                && data_byte != wrp_pkg::wave_byte(idx_reg[1:0]));
                    if (mismatch)
                    begin
                        err_next   = wrp_pkg::ST_BAD_TAG;
                        phase_next = PH_DONE;
                    end
                    else if (idx_reg == 4'd11)
                    begin
                        idx_next   = 4'd0;
                        phase_next = PH_CHDR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                PH_CHDR:
                begin
                    // id then size, both little-endian: shift in from the top
                    if (idx_reg < 4'd4)
                        tag_next = {data_byte, tag_reg[31:8]};
                    else
                        size_next = {data_byte, size_reg[31:8]};
                    if (idx_reg == 4'd7)
                    begin
                        idx_next = 4'd0;
                        if (tag_reg == wrp_pkg::TAG_FMT)
                            kind_next = KIND_FMT;
                        else if (tag_reg == wrp_pkg::TAG_DATA)
                            kind_next = KIND_DATA;
                        else
                            kind_next = KIND_OTHER;
                        stg_off_next = pos_reg + 32'd1;
                        remain_next  = size_next;
                        phase_next   = PH_BODY;
                        fin          = (size_next == 32'd0);
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                PH_BODY:
                begin
                    if (kind_reg == KIND_FMT)
                    begin
                        unique case (body_off)
                            32'd0:   fcode_next[7:0]      = data_byte;
                            32'd1:   fcode_next[15:8]     = data_byte;
                            32'd2:   stg_ch_next[7:0]     = data_byte;
                            32'd3:   stg_ch_next[15:8]    = data_byte;
                            32'd4:   stg_rate_next[7:0]   = data_byte;
                            32'd5:   stg_rate_next[15:8]  = data_byte;
                            32'd6:   stg_rate_next[23:16] = data_byte;
                            32'd7:   stg_rate_next[31:24] = data_byte;
                            32'd14:  stg_bits_next[7:0]   = data_byte;
                            32'd15:  stg_bits_next[15:8]  = data_byte;
                            default: ;
                        endcase
                    end
                    remain_next = remain_reg - 32'd1;
                    fin         = (remain_reg == 32'd1);
                end
                PH_PAD:
                begin
                    phase_next = PH_CHDR;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            // body complete: take over fields and run the chunk checks
            if (fin)
            begin
                if (kind_next == KIND_FMT)
                begin
                    if (size_next < wrp_pkg::FMT_MIN)
                    begin
                        err_next = wrp_pkg::ST_FMT_SHORT;
                    end
                    else
                    begin
                        cap_ch_next   = stg_ch_next;
                        cap_rate_next = stg_rate_next;
                        cap_bits_next = stg_bits_next;
                        if (fcode_next != wrp_pkg::FMT_PCM)
                            err_next = wrp_pkg::ST_NOT_PCM;
                        else if (stg_bits_next != wrp_pkg::PCM_BITS)
                            err_next = wrp_pkg::ST_NOT_16BIT;
                        else if (stg_ch_next == 16'd0)
                            err_next = wrp_pkg::ST_ZERO_CH;
                        else
                            fmt_seen_next = 1'b1;
                    end
                end
                else if (kind_next == KIND_DATA)
                begin
                    cap_off_next   = stg_off_next;
                    cap_bytes_next = size_next;
                    data_seen_next = 1'b1;
                end
                if (err_next != wrp_pkg::ST_OK)
                    phase_next = PH_DONE;
                else if (size_next[0])
                    phase_next = PH_PAD;
                else
                    phase_next = PH_CHDR;
            end
        end

        pos_next = (pos_reg == wrp_pkg::POS_MAX) ? pos_reg : pos_reg + 32'd1;

        if (err_next != wrp_pkg::ST_OK)
            status = err_next;
        else if (phase_next == PH_RIFF || phase_next == PH_BODY)
            status = wrp_pkg::ST_TRUNC;
        else if (!fmt_seen_next)
            status = wrp_pkg::ST_NO_FMT;
        else if (!data_seen_next)
            status = wrp_pkg::ST_NO_DATA;
        else if (cap_bytes_next[0])
            status = wrp_pkg::ST_ODD_DATA;
        else
            status = wrp_pkg::ST_OK;

        result.status      = status;
        result.channels    = cap_ch_next;
        result.rate_hz     = cap_rate_next;
        result.sample_bits = cap_bits_next;
        result.body_start  = cap_off_next;
        result.body_len    = cap_bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RIFF;
            kind_reg      <= KIND_OTHER;
            err_reg       <= wrp_pkg::ST_OK;
            pos_reg       <= '0;
            idx_reg       <= '0;
            tag_reg       <= '0;
            size_reg      <= '0;
            remain_reg    <= '0;
            fcode_reg     <= '0;
            stg_ch_reg    <= '0;
            stg_rate_reg  <= '0;
            stg_bits_reg  <= '0;
            stg_off_reg   <= '0;
            cap_ch_reg    <= '0;
            cap_rate_reg  <= '0;
            cap_bits_reg  <= '0;
            cap_off_reg   <= '0;
            cap_bytes_reg <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
        end
        else if (take && last_byte)
        begin
            // final byte: start over at the RIFF header
            phase_reg     <= PH_RIFF;
            kind_reg      <= KIND_OTHER;
            err_reg       <= wrp_pkg::ST_OK;
            pos_reg       <= '0;
            idx_reg       <= '0;
            tag_reg       <= '0;
            size_reg      <= '0;
            remain_reg    <= '0;
            fcode_reg     <= '0;
            stg_ch_reg    <= '0;
            stg_rate_reg  <= '0;
            stg_bits_reg  <= '0;
            stg_off_reg   <= '0;
            cap_ch_reg    <= '0;
            cap_rate_reg  <= '0;
            cap_bits_reg  <= '0;
            cap_off_reg   <= '0;
            cap_bytes_reg <= '0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            err_reg       <= err_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            tag_reg       <= tag_next;
            size_reg      <= size_next;
            remain_reg    <= remain_next;
            fcode_reg     <= fcode_next;
            stg_ch_reg    <= stg_ch_next;
            stg_rate_reg  <= stg_rate_next;
            stg_bits_reg  <= stg_bits_next;
            stg_off_reg   <= stg_off_next;
            cap_ch_reg    <= cap_ch_next;
            cap_rate_reg  <= cap_rate_next;
            cap_bits_reg  <= cap_bits_next;
            cap_off_reg   <= cap_off_next;
            cap_bytes_reg <= cap_bytes_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
        end
    end

endmodule

// ===== hdl/wrp_checker.sv =====
// Port-level checks for the WAV RIFF header parser, bound to the top level.
module wrp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [wrp_pkg::TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only a final byte transfer raises a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result without final byte");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= wrp_pkg::ST_ODD_DATA)
        else $error("status code out of range");

    // a clean file has 16-bit samples, channels and an even data length
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == wrp_pkg::ST_OK
        |-> m_tdata[67:52] == wrp_pkg::PCM_BITS && m_tdata[19:4] != 16'd0
            && !m_tdata[100])
        else $error("ok status with bad fields");

endmodule

bind wav_riff_header_parser_top wrp_checker u_wrp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/wav_riff_header_parser_top_test.sv =====
// Self-checking stream test of the WAV RIFF header parser with a built-in header predictor.
module wav_riff_header_parser_top_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam bit [31:0]   RIFF_ID     = 32'h4646_4952;  // "RIFF" as read little-endian
    localparam bit [31:0]   WAVE_ID     = 32'h4556_4157;  // "WAVE"

    typedef enum logic [2:0] {PH_HDR, PH_CHDR, PH_BODY, PH_PAD, PH_DONE} parse_phase_t;
    typedef enum logic [1:0] {K_OTHER, K_FMT, K_DATA} chunk_kind_t;

    class wav_header_predictor_t;
        wrp_pkg::result_t pending_results[$];
        int unsigned      mismatches;
        int unsigned      results_made;
        bit [31:0]        pos;
        parse_phase_t     phase;
        int unsigned      fidx;
        bit [31:0]        tag_sh;
        bit [31:0]        csize;
        bit [32:0]        remain;
        chunk_kind_t      kind;
        bit [15:0]        fcode;
        bit [15:0]        stg_ch;
        bit [31:0]        stg_rate;
        bit [15:0]        stg_bits;
        bit [31:0]        stg_off;
        bit [15:0]        cap_ch;
        bit [31:0]        cap_rate;
        bit [15:0]        cap_bits;
        bit [31:0]        cap_off;
        bit [31:0]        cap_bytes;
        bit               fmt_ok;
        bit               data_ok;
        wrp_pkg::status_t err;

        function new();
            mismatches   = 0;
            results_made = 0;
            clear();
        endfunction

        function void clear();
            pos       = '0;
            phase     = PH_HDR;
            fidx      = 0;
            tag_sh    = '0;
            csize     = '0;
            remain    = '0;
            kind      = K_OTHER;
            fcode     = '0;
            stg_ch    = '0;
            stg_rate  = '0;
            stg_bits  = '0;
            stg_off   = '0;
            cap_ch    = '0;
            cap_rate  = '0;
            cap_bits  = '0;
            cap_off   = '0;
            cap_bytes = '0;
            fmt_ok    = 1'b0;
            data_ok   = 1'b0;
            err       = wrp_pkg::ST_OK;
        endfunction

        // Take over a chunk once its whole body has arrived.
        function void close_chunk();
            if (kind == K_FMT) begin
                if (csize < wrp_pkg::FMT_MIN) begin
                    err = wrp_pkg::ST_FMT_SHORT;
                end else begin
                    cap_ch   = stg_ch;
                    cap_rate = stg_rate;
                    cap_bits = stg_bits;
                    if (fcode != wrp_pkg::FMT_PCM)
                        err = wrp_pkg::ST_NOT_PCM;
                    else if (cap_bits != wrp_pkg::PCM_BITS)
                        err = wrp_pkg::ST_NOT_16BIT;
                    else if (cap_ch == 16'd0)
                        err = wrp_pkg::ST_ZERO_CH;
                    else
                        fmt_ok = 1'b1;
                end
            end else if (kind == K_DATA) begin
                cap_off   = stg_off;
                cap_bytes = csize;
                data_ok   = 1'b1;
            end
            if (err != wrp_pkg::ST_OK)
                phase = PH_DONE;
            else if (csize[0])
                phase = PH_PAD;
            else
                phase = PH_CHDR;
        endfunction

        function void parse_byte(bit [7:0] b);
            bit [31:0] off;
            case (phase)
                PH_HDR: begin
                    if (fidx < 4 && b != RIFF_ID[8*fidx +: 8])
                        err = wrp_pkg::ST_BAD_TAG;
                    else if (fidx >= 8 && b != WAVE_ID[8*(fidx-8) +: 8])
                        err = wrp_pkg::ST_BAD_TAG;
                    if (err != wrp_pkg::ST_OK) begin
                        phase = PH_DONE;
                    end else begin
                        fidx++;
                        if (fidx == 12) begin
                            phase = PH_CHDR;
                            fidx  = 0;
                        end
                    end
                end
                PH_CHDR: begin
                    if (fidx < 4)
                        tag_sh = {b, tag_sh[31:8]};
                    else
                        csize = {b, csize[31:8]};
                    fidx++;
                    if (fidx == 8) begin
                        fidx = 0;
                        if (tag_sh == wrp_pkg::TAG_FMT)
                            kind = K_FMT;
                        else if (tag_sh == wrp_pkg::TAG_DATA)
                            kind = K_DATA;
                        else
                            kind = K_OTHER;
                        stg_off = pos + 32'd1;
                        remain  = {1'b0, csize};
                        phase   = PH_BODY;
                        if (remain == '0)
                            close_chunk();
                    end
                end
                PH_BODY: begin
                    off = csize - remain[31:0];
                    if (kind == K_FMT) begin
                        case (off)
                            32'd0:  fcode[7:0]   = b;
                            32'd1:  fcode[15:8]  = b;
                            32'd2:  stg_ch[7:0]  = b;
                            32'd3:  stg_ch[15:8] = b;
                            32'd4, 32'd5, 32'd6, 32'd7: stg_rate[8*(off-4) +: 8] = b;
                            32'd14: stg_bits[7:0]  = b;
                            32'd15: stg_bits[15:8] = b;
                            default: ;
                        endcase
                    end
                    remain = remain - 33'd1;
                    if (remain == '0)
                        close_chunk();
                end
                PH_PAD: phase = PH_CHDR;
                default: ;
            endcase
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            wrp_pkg::result_t r;
            if (err == wrp_pkg::ST_OK && pos == wrp_pkg::POS_MAX) begin
                err   = wrp_pkg::ST_TRUNC;
                phase = PH_DONE;
            end
            if (err == wrp_pkg::ST_OK)
                parse_byte(b);
            if (pos != wrp_pkg::POS_MAX)
                pos++;
            if (!last)
                return;
            if (err != wrp_pkg::ST_OK)
                r.status = err;
            else if (phase == PH_HDR || phase == PH_BODY)
                r.status = wrp_pkg::ST_TRUNC;
            else if (!fmt_ok)
                r.status = wrp_pkg::ST_NO_FMT;
            else if (!data_ok)
                r.status = wrp_pkg::ST_NO_DATA;
            else if (cap_bytes[0])
                r.status = wrp_pkg::ST_ODD_DATA;
            else
                r.status = wrp_pkg::ST_OK;
            r.channels    = cap_ch;
            r.rate_hz     = cap_rate;
            r.sample_bits = cap_bits;
            r.body_start  = cap_off;
            r.body_len    = cap_bytes;
            pending_results.push_back(r);
            results_made++;
            clear();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(wrp_pkg::result_t got);
            wrp_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with no file outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("channels", 32'(want.channels), 32'(got.channels));
            compare_field("rate_hz", want.rate_hz, got.rate_hz);
            compare_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
            compare_field("body_start", want.body_start, got.body_start);
            compare_field("body_len", want.body_len, got.body_len);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = 8'd0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [wrp_pkg::TDATA_W-1:0] m_tdata;

    wav_header_predictor_t predictor = new();
    logic [7:0]            file_q[$];
    bit                    steady = 1'b0;
    int unsigned           bytes_sent = 0;
    int unsigned           cycles = 0;

    wav_riff_header_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next ready.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            predictor.check_result(wrp_pkg::result_t'(m_tdata[wrp_pkg::RESULT_W-1:0]));
        if (rst_n)
            m_tready <= steady || ($urandom_range(99) >= 38);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        // idle at random before each byte unless steady
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predictor.note_byte(b, last);
    endtask

    task automatic send_file();
        int unsigned n;
        n = file_q.size();
        for (int unsigned i = 0; i < n; i++)
            send_byte(file_q[i], i == n - 1);
        bytes_sent += n;
        file_q.delete();
    endtask

    function automatic void put32(bit [31:0] v);
        for (int i = 0; i < 4; i++)
            file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_header();
        put32(RIFF_ID);
        put32($urandom);
        put32(WAVE_ID);
    endfunction

    function automatic void put_random(int unsigned n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    // Chunk with random body; odd sizes get their pad byte.
    function automatic void put_chunk(bit [31:0] id, bit [31:0] size);
        put32(id);
        put32(size);
        put_random(size);
        if (size[0])
            put_random(1);
    endfunction

    function automatic void put_fmt(bit [31:0] size, bit [15:0] code, bit [15:0] ch,
                                    bit [31:0] rate, bit [15:0] bits);
        bit [127:0] body;
        body = {bits, 16'($urandom), 32'($urandom), rate, ch, code};
        put32(wrp_pkg::TAG_FMT);
        put32(size);
        for (int unsigned i = 0; i < size; i++)
            file_q.push_back(i < 16 ? body[8*i +: 8] : 8'($urandom));
        if (size[0])
            put_random(1);
    endfunction

    function automatic void put_good_fmt();
        put_fmt(wrp_pkg::FMT_MIN, wrp_pkg::FMT_PCM, 16'($urandom_range(1, 8)), $urandom,
                wrp_pkg::PCM_BITS);
    endfunction

    function automatic void drop_tail(int unsigned n);
        repeat (n)
            if (file_q.size() > 1)
                void'(file_q.pop_back());
    endfunction

    task automatic run_directed();
        put_header(); put_good_fmt(); put_chunk(wrp_pkg::TAG_DATA, 4); send_file();
        // bad first tag byte, alone
        file_q.push_back(8'h58); send_file();
        // stream ends inside the header
        put32(RIFF_ID); drop_tail(1); send_file();
        put32(RIFF_ID); put32(0); put32(WAVE_ID ^ 32'h0100_0000); send_file();
        put_header(); put_fmt(15, wrp_pkg::FMT_PCM, 16'd2, 8000, wrp_pkg::PCM_BITS);
        put_chunk(wrp_pkg::TAG_DATA, 2);
        send_file();
        put_header(); put_fmt(16, 16'd3, 16'd2, 48000, wrp_pkg::PCM_BITS); send_file();
        put_header(); put_fmt(16, wrp_pkg::FMT_PCM, 16'd1, 22050, 16'd8); send_file();
        put_header(); put_fmt(18, wrp_pkg::FMT_PCM, 16'd0, 11025, wrp_pkg::PCM_BITS);
        send_file();
        put_header(); put_chunk(wrp_pkg::TAG_DATA, 6); send_file();
        put_header(); put_good_fmt(); send_file();
        put_header(); put_good_fmt(); put_chunk(wrp_pkg::TAG_DATA, 3); send_file();
        // data body cut off by the end of the stream
        put_header(); put_good_fmt(); put_chunk(wrp_pkg::TAG_DATA, 10); drop_tail(4);
        send_file();
        // short trailing bytes are ignored
        put_header(); put_good_fmt(); put_chunk(wrp_pkg::TAG_DATA, 2); put_random(7);
        send_file();
        // missing final pad byte
        put_header(); put_good_fmt(); put_chunk(wrp_pkg::TAG_DATA, 5); drop_tail(1);
        send_file();
        // fmt cut off before its checks
        put_header(); put_fmt(16, 16'd7, 16'd0, 0, 16'd0); drop_tail(3); send_file();
        // field extremes, zero and odd other chunks, data overwritten, odd fmt
        put_header(); put_chunk(32'h5453_494C, 0); put_chunk(32'hFFFF_FFFF, 1);
        put_fmt(17, wrp_pkg::FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, wrp_pkg::PCM_BITS);
        put_chunk(wrp_pkg::TAG_DATA, 1); put_chunk(wrp_pkg::TAG_DATA, 0); send_file();
        put_header(); put_good_fmt(); put32(wrp_pkg::TAG_DATA); put32(32'hFFFF_FFFF);
        put_random(3);
        send_file();
        put_header(); put_good_fmt(); put32(wrp_pkg::TAG_FMT); put32(32'h8000_0000);
        send_file();
    endtask

    // Mostly well-formed files with random content, then a random ending.
    function automatic void gen_wav_file();
        int unsigned n;
        int unsigned pick;
        bit [31:0]   size;
        bit [15:0]   code;
        bit [15:0]   bits;
        bit [15:0]   ch;
        put_header();
        n = $urandom_range(1, 4);
        repeat (n) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(0, 15)
                                                : 16 + $urandom_range(0, 6);
                code = ($urandom_range(9) == 0) ? 16'($urandom) : wrp_pkg::FMT_PCM;
                bits = ($urandom_range(9) == 0) ? 16'($urandom) : wrp_pkg::PCM_BITS;
                ch   = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
                put_fmt(size, code, ch, $urandom, bits);
            end else if (pick < 7) begin
                put_chunk(wrp_pkg::TAG_DATA, $urandom_range(0, 24));
            end else begin
                put_chunk($urandom, $urandom_range(0, 12));
            end
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            drop_tail($urandom_range(1, 12));
        end else if (pick < 22) begin
            put_random($urandom_range(1, 7));
        end else if (pick < 28) begin
            put32(($urandom_range(1) == 1) ? wrp_pkg::TAG_DATA : $urandom);
            put32($urandom);
            put_random($urandom_range(0, 5));
        end
    endfunction

    // Noise, header prefixes and damaged headers.
    function automatic void gen_broken_file();
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        if (pick < 40) begin
            put_random($urandom_range(1, 16));
        end else if (pick < 75) begin
            put_header();
            drop_tail($urandom_range(0, 11));
            if ($urandom_range(1) == 1) begin
                k = $urandom_range(0, file_q.size() - 1);
                file_q[k] = file_q[k] ^ (8'd1 << $urandom_range(7));
            end
        end else begin
            put_header();
            put_random($urandom_range(0, 20));
        end
    endfunction

    initial begin
        int unsigned file_count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        file_count = 0;
        while (bytes_sent < 1250) begin
            steady = (file_count >= 10 && file_count < 20);
            if ($urandom_range(99) < 75)
                gen_wav_file();
            else
                gen_broken_file();
            send_file();
            file_count++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        steady = 1'b0;
        while (predictor.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (predictor.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
